[hw/rtl/boot_rollback_history_manager_assert.svh]
// Assertion macros for the boot rollback history manager.
`ifndef BOOT_ROLLBACK_HISTORY_MANAGER_ASSERT_SVH
`define BOOT_ROLLBACK_HISTORY_MANAGER_ASSERT_SVH

// Overlapping implication, checked at every clock edge outside reset.
`define BRHM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brhm check failed");

// Next-cycle implication, checked outside reset.
`define BRHM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brhm check failed");

`endif

[hw/rtl/brhm_pkg.sv]
// Shared types and constants of the boot rollback history manager.
package brhm_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [3:0] {
      FN_INSTALL  = 4'd0,
      FN_ATTEMPT  = 4'd1,
      FN_RESULT   = 4'd2,
      FN_CHECK    = 4'd3,
      FN_EXECUTE  = 4'd4,
      FN_CONFIRM  = 4'd5,
      FN_CLEAR    = 4'd6,
      FN_RESET    = 4'd7,
      FN_SET_CUR  = 4'd8
   } func_type;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_CHECKING  = 3'd1,
      MODE_EXECUTING = 3'd2,
      MODE_VERIFYING = 3'd3,
      MODE_COMPLETED = 3'd4,
      MODE_FAILED    = 3'd5
   } mode_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_PREV = 2'd1;
   localparam logic [1:0] STATUS_BUSY    = 2'd2;

   localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;

   localparam logic CSR_MAX_FAILURES = 1'b1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE
   } seq_type;

   typedef enum logic [2:0] {
      TBL_NOP,
      TBL_WRITE,
      TBL_SHIFT_WRITE,
      TBL_BUMP,
      TBL_CLEAR
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type       op;
      logic [IDX_W-1:0] idx;
      logic [31:0]      version;
      logic [7:0]       partition;
   } tbl_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] version;
      logic [7:0]  partition;
      logic [15:0] boots;
      logic [15:0] success_count;
   } tbl_entry_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] version_in;
      logic [7:0]  partition_in;
      logic [1:0]  boot_outcome;
      logic [7:0]  rollback_reason;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        rb_needed;
      logic [31:0] tgt_version;
      logic [7:0]  tgt_partition;
      logic [2:0]  manager_state;
      logic        dtc_valid;
      logic [1:0]  dtc_kind;
      logic        rollback_active;
      logic [7:0]  failure_count;
      logic [7:0]  attempt_count;
      logic [15:0] rollbacks_done;
      logic [3:0]  entries_used;
   } rsp_type;

endpackage

[hw/rtl/boot_rollback_history_manager.sv]
// Top level: command sequencer, table scan, result register and CSR port.
// A command walks the table scan, the update in SEQ_DONE and the registered result on
// rsp_strobe. A new command is taken only while busy is low; busy drops while the result
// is shown, and the single table read port and 32-bit compare walk one entry per cycle.
// Reset (synchronous): table empty, counters zero, mode idle, limits back to 3.
// Results are shown for one cycle on rsp_strobe; the receiver cannot stall.
module boot_rollback_history_manager import brhm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------- configuration registers ----------------
   logic [7:0] max_att_ff, max_fail_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_MAX_FAILURES) ? {24'd0, max_fail_ff}
                                                  : {24'd0, max_att_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff  <= 8'd3;
         max_fail_ff <= 8'd3;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == CSR_MAX_FAILURES) max_fail_ff <= pwdata[7:0];
         else                              max_att_ff  <= pwdata[7:0];
      end
   end

   // ---------------- sequencer and scan state ----------------
   seq_type seq_ff, seq_in;
   req_type req_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // first-hit trackers filled during the scan
   logic match_ff, match_in, free_ff, free_in;
   logic good_ff, good_in, elig_ff, elig_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [31:0] good_ver_ff, good_ver_in, elig_ver_ff, elig_ver_in;
   logic [7:0]  good_part_ff, good_part_in, elig_part_ff, elig_part_in;

   // architectural state
   logic [31:0] cur_ver_ff, cur_ver_in, dest_ver_ff, dest_ver_in;
   logic [7:0]  cur_part_ff, cur_part_in, dest_part_ff, dest_part_in;
   logic [7:0]  attempts_ff, attempts_in, fails_ff, fails_in;
   logic        active_ff, active_in;
   logic [15:0] rb_total_ff, rb_total_in;
   logic [CNT_W-1:0] used_ff, used_in;
   mode_type    mode_ff, mode_in;

   rsp_type rsp_ff, rsp_in;
   logic    strobe_ff, strobe_in;

   tbl_cmd_type   tcmd;
   tbl_entry_type ent;

   brhm_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .cmd      (tcmd),
      .rd_entry (ent)
   );

   // shared compare: install looks up the new version, all else the current one
   logic [31:0] key;
   logic        key_eq;
   assign key    = (req_ff.func == FN_INSTALL) ? req_ff.version_in : cur_ver_ff;
   assign key_eq = (ent.version == key);

   assign busy       = (seq_ff != SEQ_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      logic pick_ok;
      logic [31:0] pick_ver;
      logic [7:0]  pick_part;
      logic need;

      seq_in = seq_ff;
      idx_in = idx_ff;
      match_in = match_ff; free_in = free_ff; good_in = good_ff; elig_in = elig_ff;
      match_idx_in = match_idx_ff; free_idx_in = free_idx_ff;
      good_ver_in = good_ver_ff; good_part_in = good_part_ff;
      elig_ver_in = elig_ver_ff; elig_part_in = elig_part_ff;
      cur_ver_in = cur_ver_ff; cur_part_in = cur_part_ff;
      dest_ver_in = dest_ver_ff; dest_part_in = dest_part_ff;
      attempts_in = attempts_ff; fails_in = fails_ff;
      active_in = active_ff; rb_total_in = rb_total_ff;
      used_in = used_ff; mode_in = mode_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      tcmd = '{op: TBL_NOP, idx: '0, version: req_ff.version_in,
               partition: req_ff.partition_in};

      pick_ok   = good_ff || elig_ff;
      pick_ver  = good_ff ? good_ver_ff  : (elig_ff ? elig_ver_ff  : 32'd0);
      pick_part = good_ff ? good_part_ff : (elig_ff ? elig_part_ff : 8'd0);
      need      = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            idx_in = '0;
            match_in = 1'b0; free_in = 1'b0; good_in = 1'b0; elig_in = 1'b0;
            if (start) seq_in = SEQ_SCAN;
         end
         SEQ_SCAN: begin
            if (ent.valid && key_eq && !match_ff) begin
               match_in = 1'b1; match_idx_in = idx_ff;
            end
            if (!ent.valid && !free_ff) begin
               free_in = 1'b1; free_idx_in = idx_ff;
            end
            if (ent.valid && !key_eq && !elig_ff) begin
               elig_in = 1'b1; elig_ver_in = ent.version; elig_part_in = ent.partition;
            end
            if (ent.valid && !key_eq && ent.success_count != 16'd0 && !good_ff) begin
               good_in = 1'b1; good_ver_in = ent.version; good_part_in = ent.partition;
            end
            if (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) seq_in = SEQ_DONE;
            else idx_in = idx_ff + 1'b1;
         end
         SEQ_DONE: begin
            rsp_in = '0;
            rsp_in.status = STATUS_OK;
            case (req_ff.func)
               FN_INSTALL: begin
                  if (!match_ff) begin
                     tcmd.op  = free_ff ? TBL_WRITE : TBL_SHIFT_WRITE;
                     tcmd.idx = free_idx_ff;
                     if (used_ff != CNT_W'(HISTORY_DEPTH)) used_in = used_ff + 1'b1;
                  end
                  attempts_in = 8'd0; fails_in = 8'd0;
                  cur_ver_in = req_ff.version_in; cur_part_in = req_ff.partition_in;
               end
               FN_ATTEMPT: begin
                  if (attempts_ff != 8'hFF) attempts_in = attempts_ff + 8'd1;
               end
               FN_RESULT: begin
                  if (req_ff.boot_outcome == OUTCOME_SUCCESS) begin
                     attempts_in = 8'd0; fails_in = 8'd0;
                     if (match_ff) begin
                        tcmd.op = TBL_BUMP; tcmd.idx = match_idx_ff;
                     end
                  end else begin
                     if (fails_ff != 8'hFF) fails_in = fails_ff + 8'd1;
                     rsp_in.dtc_valid = 1'b1;
                     rsp_in.dtc_kind  = req_ff.boot_outcome - 2'd1;
                  end
               end
               FN_CHECK: begin
                  mode_in = MODE_CHECKING;
                  if (active_ff) begin
                     rsp_in.rb_needed     = 1'b1;
                     rsp_in.tgt_version   = dest_ver_ff;
                     rsp_in.tgt_partition = dest_part_ff;
                  end else begin
                     need = (attempts_ff >= max_att_ff) || (fails_ff >= max_fail_ff);
                     if (need) begin
                        if (!pick_ok) begin
                           rsp_in.status = STATUS_NO_PREV;
                        end else begin
                           rsp_in.rb_needed     = 1'b1;
                           rsp_in.tgt_version   = pick_ver;
                           rsp_in.tgt_partition = pick_part;
                        end
                     end
                  end
               end
               FN_EXECUTE: begin
                  if (active_ff) begin
                     rsp_in.status        = STATUS_BUSY;
                     rsp_in.tgt_version   = dest_ver_ff;
                     rsp_in.tgt_partition = dest_part_ff;
                  end else if (!pick_ok) begin
                     mode_in = MODE_FAILED;
                     rsp_in.status = STATUS_NO_PREV;
                  end else begin
                     rsp_in.tgt_version   = pick_ver;
                     rsp_in.tgt_partition = pick_part;
                     active_in = 1'b1;
                     dest_ver_in = pick_ver; dest_part_in = pick_part;
                     if (rb_total_ff != 16'hFFFF) rb_total_in = rb_total_ff + 16'd1;
                     mode_in = MODE_VERIFYING;
                  end
               end
               FN_CONFIRM: begin
                  if (active_ff) begin
                     active_in = 1'b0;
                     cur_ver_in = dest_ver_ff; cur_part_in = dest_part_ff;
                     attempts_in = 8'd0; fails_in = 8'd0;
                     mode_in = MODE_COMPLETED;
                  end
               end
               FN_CLEAR: begin
                  active_in = 1'b0; attempts_in = 8'd0; fails_in = 8'd0;
                  mode_in = MODE_IDLE;
               end
               FN_RESET: begin
                  tcmd.op = TBL_CLEAR;
                  used_in = '0; rb_total_in = 16'd0; active_in = 1'b0;
                  attempts_in = 8'd0; fails_in = 8'd0;
               end
               FN_SET_CUR: begin
                  cur_ver_in = req_ff.version_in; cur_part_in = req_ff.partition_in;
               end
               default: ;
            endcase
            rsp_in.manager_state   = mode_in;
            rsp_in.rollback_active = active_in;
            rsp_in.failure_count   = fails_in;
            rsp_in.attempt_count   = attempts_in;
            rsp_in.rollbacks_done  = rb_total_in;
            rsp_in.entries_used    = 4'(used_in);
            strobe_in = 1'b1;
            seq_in = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         strobe_ff <= 1'b0;
         cur_ver_ff <= '0; cur_part_ff <= '0;
         dest_ver_ff <= '0; dest_part_ff <= '0;
         attempts_ff <= '0; fails_ff <= '0;
         active_ff <= 1'b0; rb_total_ff <= '0;
         used_ff <= '0; mode_ff <= MODE_IDLE;
      end else begin
         seq_ff <= seq_in;
         strobe_ff <= strobe_in;
         cur_ver_ff <= cur_ver_in; cur_part_ff <= cur_part_in;
         dest_ver_ff <= dest_ver_in; dest_part_ff <= dest_part_in;
         attempts_ff <= attempts_in; fails_ff <= fails_in;
         active_ff <= active_in; rb_total_ff <= rb_total_in;
         used_ff <= used_in; mode_ff <= mode_in;
      end
   end

   // scan trackers and payload: no reset needed
   always_ff @(posedge clock) begin
      if (seq_ff == SEQ_IDLE && start) req_ff <= req_item;
      idx_ff <= idx_in;
      match_ff <= match_in; free_ff <= free_in; good_ff <= good_in; elig_ff <= elig_in;
      match_idx_ff <= match_idx_in; free_idx_ff <= free_idx_in;
      good_ver_ff <= good_ver_in; good_part_ff <= good_part_in;
      elig_ver_ff <= elig_ver_in; elig_part_ff <= elig_part_in;
      rsp_ff <= rsp_in;
   end

`include "boot_rollback_history_manager_assert.svh"

   // a transfer starts a command that holds busy through the scan
   `BRHM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   // every result strobe closes a command that was in flight
   `BRHM_ASSERT_NOW(a_strobe_after_busy, rsp_strobe, $past(busy))
   // a trouble code only comes with a failed boot result kind in range
   `BRHM_ASSERT_NOW(a_dtc_kind, rsp_strobe && rsp_item.dtc_valid, rsp_item.dtc_kind != 2'd3)
   // rollback need is never reported together with a missing target
   `BRHM_ASSERT_NOW(a_need_status, rsp_strobe && rsp_item.rb_needed,
                    rsp_item.status == STATUS_OK)

endmodule

[hw/rtl/brhm_table.sv]
// History table: entry registers, one read port, write/shift/bump/clear ops.
module brhm_table import brhm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   input  tbl_cmd_type      cmd,
   output tbl_entry_type    rd_entry
);

   tbl_entry_type entry_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;

   assign rd_entry = '{valid: valid_ff[rd_idx],
                       version: entry_ff[rd_idx].version,
                       partition: entry_ff[rd_idx].partition,
                       boots: entry_ff[rd_idx].boots,
                       success_count: entry_ff[rd_idx].success_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         case (cmd.op)
            TBL_WRITE: valid_ff[cmd.idx] <= 1'b1;
            TBL_SHIFT_WRITE: valid_ff <= '1;
            TBL_CLEAR: valid_ff <= '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         TBL_WRITE: begin
            entry_ff[cmd.idx] <= '{valid: 1'b1, version: cmd.version,
                                   partition: cmd.partition,
                                   boots: 16'd0, success_count: 16'd0};
         end
         TBL_SHIFT_WRITE: begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               entry_ff[i] <= entry_ff[i+1];
            end
            entry_ff[HISTORY_DEPTH-1] <= '{valid: 1'b1, version: cmd.version,
                                           partition: cmd.partition,
                                           boots: 16'd0, success_count: 16'd0};
         end
         TBL_BUMP: begin
            if (entry_ff[cmd.idx].boots != 16'hFFFF)
               entry_ff[cmd.idx].boots <= entry_ff[cmd.idx].boots + 16'd1;
            if (entry_ff[cmd.idx].success_count != 16'hFFFF)
               entry_ff[cmd.idx].success_count <= entry_ff[cmd.idx].success_count + 16'd1;
         end
         default: ;
      endcase
   end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the boot rollback history manager.
module testbench;
   import brhm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = HISTORY_DEPTH + 6;
   localparam int RANDOM_ITEMS = 240;

   localparam logic [1:0] OUTCOME_WATCHDOG = 2'd1;
   localparam logic [1:0] OUTCOME_SECURITY = 2'd2;
   localparam logic [1:0] OUTCOME_OTHER    = 2'd3;
   localparam logic [3:0] FN_SPARE_LO      = 4'd9;
   localparam logic [3:0] FN_SPARE_HI      = 4'd15;
   localparam logic [2:0] CSR_ADDR_ATTEMPTS = 3'd0;
   localparam logic [2:0] CSR_ADDR_FAILURES = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   boot_rollback_history_manager dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the manager: history table, counters, rollback record
   // ---------------------------------------------------------------------
   logic [31:0] h_ver[HISTORY_DEPTH];
   logic [7:0]  h_part[HISTORY_DEPTH];
   logic        h_valid[HISTORY_DEPTH];
   logic [15:0] h_boots[HISTORY_DEPTH];
   logic [15:0] h_goods[HISTORY_DEPTH];
   logic [31:0] cur_ver = '0;
   logic [7:0]  cur_part = '0;
   logic [7:0]  attempts = '0;
   logic [7:0]  fails = '0;
   logic        rb_active = 1'b0;
   logic [31:0] dest_ver = '0;
   logic [7:0]  dest_part = '0;
   logic [15:0] rb_total = '0;
   int          used = 0;
   mode_type    mode = MODE_IDLE;
   logic [7:0]  lim_attempts = 8'd3;
   logic [7:0]  lim_failures = 8'd3;

   rsp_type     pending_rsp[$];   // results predicted but not yet strobed
   int          mismatches = 0;
   int          rsp_seen = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          rollbacks_seen = 0;

   function automatic void wipe_slot(int i);
      h_ver[i] = '0; h_part[i] = '0; h_valid[i] = 1'b0; h_boots[i] = '0; h_goods[i] = '0;
   endfunction

   function automatic int find_version(logic [31:0] v);
      for (int i = 0; i < HISTORY_DEPTH; i++)
         if (h_valid[i] && h_ver[i] == v) return i;
      return -1;
   endfunction

   // Proven fallback first: a booted-ok older image beats a never-booted one.
   function automatic int choose_fallback();
      for (int i = 0; i < HISTORY_DEPTH; i++)
         if (h_valid[i] && h_ver[i] != cur_ver && h_goods[i] != 0) return i;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         if (h_valid[i] && h_ver[i] != cur_ver) return i;
      return -1;
   endfunction

   function automatic void add_version(logic [31:0] v, logic [7:0] p);
      int slot;
      slot = -1;
      if (find_version(v) >= 0) return;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         if (!h_valid[i] && slot < 0) slot = i;
      // full table: drop the oldest, shift everything down one
      if (slot < 0) begin
         for (int i = 0; i + 1 < HISTORY_DEPTH; i++) begin
            h_ver[i] = h_ver[i+1]; h_part[i] = h_part[i+1]; h_valid[i] = h_valid[i+1];
            h_boots[i] = h_boots[i+1]; h_goods[i] = h_goods[i+1];
         end
         slot = HISTORY_DEPTH - 1;
      end
      wipe_slot(slot);
      h_ver[slot] = v; h_part[slot] = p; h_valid[slot] = 1'b1;
      if (used < HISTORY_DEPTH) used++;
   endfunction

   function automatic rsp_type manager_outcome(req_type q);
      rsp_type r;
      int idx;
      r = '0;
      case (q.func)
         FN_INSTALL: begin
            add_version(q.version_in, q.partition_in);
            attempts = '0; fails = '0;
            cur_ver = q.version_in; cur_part = q.partition_in;
         end
         FN_ATTEMPT: if (attempts != 8'hFF) attempts++;
         FN_RESULT: begin
            if (q.boot_outcome == OUTCOME_SUCCESS) begin
               attempts = '0; fails = '0;
               idx = find_version(cur_ver);
               if (idx >= 0) begin
                  if (h_boots[idx] != 16'hFFFF) h_boots[idx]++;
                  if (h_goods[idx] != 16'hFFFF) h_goods[idx]++;
               end
            end else begin
               if (fails != 8'hFF) fails++;
               r.dtc_valid = 1'b1;
               r.dtc_kind = q.boot_outcome - 2'd1;
            end
         end
         FN_CHECK: begin
            mode = MODE_CHECKING;
            if (rb_active) begin
               r.rb_needed = 1'b1;
               r.tgt_version = dest_ver; r.tgt_partition = dest_part;
            end else if (attempts >= lim_attempts || fails >= lim_failures) begin
               idx = choose_fallback();
               if (idx < 0) r.status = STATUS_NO_PREV;
               else begin
                  r.rb_needed = 1'b1;
                  r.tgt_version = h_ver[idx]; r.tgt_partition = h_part[idx];
               end
            end
         end
         FN_EXECUTE: begin
            if (rb_active) begin
               r.status = STATUS_BUSY;
               r.tgt_version = dest_ver; r.tgt_partition = dest_part;
            end else begin
               idx = choose_fallback();
               if (idx < 0) begin
                  mode = MODE_FAILED; r.status = STATUS_NO_PREV;
               end else begin
                  r.tgt_version = h_ver[idx]; r.tgt_partition = h_part[idx];
                  rb_active = 1'b1; dest_ver = h_ver[idx]; dest_part = h_part[idx];
                  if (rb_total != 16'hFFFF) rb_total++;
                  mode = MODE_VERIFYING;
                  rollbacks_seen++;
               end
            end
         end
         FN_CONFIRM: if (rb_active) begin
            rb_active = 1'b0; cur_ver = dest_ver; cur_part = dest_part;
            attempts = '0; fails = '0; mode = MODE_COMPLETED;
         end
         FN_CLEAR: begin
            rb_active = 1'b0; attempts = '0; fails = '0; mode = MODE_IDLE;
         end
         FN_RESET: begin
            for (int i = 0; i < HISTORY_DEPTH; i++) wipe_slot(i);
            used = 0; rb_total = '0; rb_active = 1'b0; fails = '0; attempts = '0;
         end
         FN_SET_CUR: begin
            cur_ver = q.version_in; cur_part = q.partition_in;
         end
         default: ;
      endcase
      r.manager_state = mode;
      r.rollback_active = rb_active;
      r.failure_count = fails;
      r.attempt_count = attempts;
      r.rollbacks_done = rb_total;
      r.entries_used = 4'(used);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking: each strobe is matched against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0d] %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         rsp_type want;
         rsp_seen++;
         if (pending_rsp.size() == 0) report("result with nothing pending", 0, 0);
         else begin
            want = pending_rsp.pop_front();
            check_field("status", rsp_item.status, want.status);
            check_field("rb_needed", rsp_item.rb_needed, want.rb_needed);
            check_field("tgt_version", rsp_item.tgt_version, want.tgt_version);
            check_field("tgt_partition", rsp_item.tgt_partition, want.tgt_partition);
            check_field("manager_state", rsp_item.manager_state, want.manager_state);
            check_field("dtc_valid", rsp_item.dtc_valid, want.dtc_valid);
            check_field("dtc_kind", rsp_item.dtc_kind, want.dtc_kind);
            check_field("rollback_active", rsp_item.rollback_active, want.rollback_active);
            check_field("failure_count", rsp_item.failure_count, want.failure_count);
            check_field("attempt_count", rsp_item.attempt_count, want.attempt_count);
            check_field("rollbacks_done", rsp_item.rollbacks_done, want.rollbacks_done);
            check_field("entries_used", rsp_item.entries_used, want.entries_used);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Command side: drive at the falling edge, watch the transfer at the rising
   // ---------------------------------------------------------------------
   // start stays high between back-to-back commands; only a gap lowers it.
   task automatic send(req_type q, bit typed, rsp_type typed_rsp);
      rsp_type guess;
      @(negedge clock);
      start <= 1'b1;
      req_item <= q;
      do @(posedge clock); while (busy);
      guess = manager_outcome(q);
      pending_rsp.push_back(typed ? typed_rsp : guess);
   endtask

   task automatic go_quiet(int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Bursts of back-to-back transfers with random gaps between them.
   task automatic issue(req_type q);
      if (burst_left == 0) begin
         go_quiet($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      send(q, 1'b0, '0);
   endtask

   task automatic drain();
      go_quiet(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [7:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_ADDR_ATTEMPTS) lim_attempts = value;
      else lim_failures = value;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic req_type cmd(func_type f, logic [31:0] v, logic [7:0] p,
                                   logic [1:0] o, logic [7:0] why);
      req_type q;
      q.func = f; q.version_in = v; q.partition_in = p;
      q.boot_outcome = o; q.rollback_reason = why;
      return q;
   endfunction

   // Small version pool so duplicates and evictions happen often.
   function automatic logic [31:0] pick_version();
      case ($urandom_range(0, 9))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         2: return $urandom();
         default: return 32'(100 + $urandom_range(0, 11));
      endcase
   endfunction

   function automatic req_type random_cmd();
      req_type q;
      int pick;
      q.version_in = pick_version();
      q.partition_in = 8'($urandom());
      q.boot_outcome = 2'($urandom());
      q.rollback_reason = 8'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 14) q.func = FN_INSTALL;
      else if (pick < 34) q.func = FN_ATTEMPT;
      else if (pick < 56) q.func = FN_RESULT;
      else if (pick < 70) q.func = FN_CHECK;
      else if (pick < 80) q.func = FN_EXECUTE;
      else if (pick < 88) q.func = FN_CONFIRM;
      else if (pick < 91) q.func = FN_CLEAR;
      else if (pick < 93) q.func = FN_RESET;
      else if (pick < 97) q.func = FN_SET_CUR;
      else q.func = 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      return q;
   endfunction

   typedef struct {
      req_type q;
      bit      typed;
      rsp_type want;
   } step_row;

   step_row script[$];

   function automatic rsp_type outcome_row(logic [1:0] st, mode_type m);
      rsp_type r;
      r = '0;
      r.status = st;
      r.manager_state = m;
      return r;
   endfunction

   function automatic void add_row(req_type q, bit typed = 0, rsp_type want = '0);
      step_row s;
      s.q = q; s.typed = typed; s.want = want;
      script.push_back(s);
   endfunction

   initial begin
      logic [7:0] att_set[4];
      logic [7:0] fail_set[4];
      for (int i = 0; i < HISTORY_DEPTH; i++) wipe_slot(i);

      // Directed script: empty-table corner cases first, then fill, evict,
      // fail boots of every kind, roll back and confirm.
      add_row(cmd(FN_CHECK, 0, 0, 0, 0), 1, outcome_row(STATUS_OK, MODE_CHECKING));
      add_row(cmd(FN_EXECUTE, 0, 0, 0, 8'hFF), 1, outcome_row(STATUS_NO_PREV, MODE_FAILED));
      add_row(cmd(FN_CONFIRM, 0, 0, 0, 0), 1, outcome_row(STATUS_OK, MODE_FAILED));
      add_row(cmd(FN_INSTALL, 32'hFFFF_FFFF, 8'hFF, 0, 0));
      add_row(cmd(FN_RESULT, 0, 0, OUTCOME_SUCCESS, 0));
      add_row(cmd(FN_INSTALL, 32'h0, 8'h00, 0, 0));
      for (int i = 1; i <= HISTORY_DEPTH - 1; i++)
         add_row(cmd(FN_INSTALL, 32'(i), 8'(i), 0, 0));
      add_row(cmd(FN_INSTALL, 32'h5, 8'h55, 0, 0));          // duplicate: table unchanged
      add_row(cmd(FN_ATTEMPT, 0, 0, 0, 0));
      add_row(cmd(FN_RESULT, 0, 0, OUTCOME_WATCHDOG, 0));
      add_row(cmd(FN_RESULT, 0, 0, OUTCOME_SECURITY, 0));
      add_row(cmd(FN_RESULT, 0, 0, OUTCOME_OTHER, 0));
      add_row(cmd(FN_CHECK, 0, 0, 0, 0));
      add_row(cmd(FN_EXECUTE, 0, 0, 0, 8'hA5));
      add_row(cmd(FN_EXECUTE, 0, 0, 0, 8'h00));              // already rolling back
      add_row(cmd(FN_CHECK, 0, 0, 0, 0));                    // check during rollback
      add_row(cmd(FN_CONFIRM, 0, 0, 0, 0));
      add_row(cmd(FN_SET_CUR, 32'hDEAD_BEEF, 8'h80, 0, 0));
      add_row(cmd(FN_RESULT, 0, 0, OUTCOME_SUCCESS, 0));     // current not in table
      add_row(cmd(FN_CLEAR, 0, 0, 0, 0));
      add_row(cmd(FN_RESET, 0, 0, 0, 0));
      add_row(cmd(func_type'(FN_SPARE_HI), 32'hFFFF_FFFF, 8'hFF, 2'd3, 8'hFF));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send(script[i].q, script[i].typed, script[i].want);

      // Limit settings per phase: both extremes, small values, random.
      att_set  = '{8'd255, 8'd0, 8'd1, 8'($urandom())};
      fail_set = '{8'd255, 8'd0, 8'd2, 8'($urandom())};
      for (int ph = 0; ph < 4; ph++) begin
         drain();   // sender holds off until every pending result is back
         csr_write(CSR_ADDR_ATTEMPTS, att_set[ph]);
         csr_write(CSR_ADDR_FAILURES, fail_set[ph]);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) issue(random_cmd());
      end
      // one late saturation run so both counters hit their ceiling at least once
      repeat (260) issue(cmd(FN_ATTEMPT, 0, 0, 0, 0));
      repeat (260) issue(cmd(FN_RESULT, 0, 0, OUTCOME_WATCHDOG, 0));
      issue(cmd(FN_CHECK, 0, 0, 0, 0));

      drain();
      $display("Covered %0d results, %0d rollbacks, four limit settings incl. 0 and 255,",
               rsp_seen, rollbacks_seen);
      $display("table eviction, duplicate installs and counter saturation.");
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("No mismatches found");
      else begin
         if (pending_rsp.size() != 0)
            $display("%0d predicted results never arrived", pending_rsp.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[boot_rollback_history_manager.f]
+incdir+hw/rtl
hw/rtl/brhm_pkg.sv
hw/rtl/brhm_table.sv
hw/rtl/boot_rollback_history_manager.sv
bench/testbench.sv
